// File: hw/rtl/csot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package of the channel speed outlier tracker: sizes, status codes and register indexes.
// It depends on nothing and is used by every other file of the block.
package csot_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int IDX_W        = $clog2(MAX_CHANNELS);
    localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
    localparam int KEY_W        = 32;
    localparam int SPD_W        = 32;
    localparam int SUM_W        = SPD_W + IDX_W;
    localparam int NX_W         = SPD_W + CNT_W;
    localparam int VAR_W        = 2 * SUM_W + IDX_W;
    localparam int DEV_W        = 16;
    localparam int MINC_W       = 5;

    localparam int MUL_A_W      = VAR_W;
    localparam int MUL_B_W      = SUM_W;
    localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W    = $clog2(MUL_B_W + 1);

    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT = 8'd1;

    localparam logic [DEV_W-1:0]  DEV_RESET  = 16'd256;
    localparam logic [MINC_W-1:0] MINC_RESET = 5'd3;

    localparam logic OP_SPEED   = 1'b0;
    localparam logic OP_STARVED = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EXHAUSTED = 3'd1;
    localparam logic [2:0] ST_STALLED   = 3'd2;
    localparam logic [2:0] ST_SLOW      = 3'd3;
    localparam logic [2:0] ST_SPLIT     = 3'd4;
    localparam logic [2:0] ST_STALL     = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

    typedef logic [2:0] status_t;

endpackage
`default_nettype wire

// File: hw/rtl/csot_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel interfaces of the tracker: update requests, results and register writes.
// They depend on csot_pkg for field widths.
interface csot_req_if
    import csot_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             op;
    logic [KEY_W-1:0] channel;
    logic [SPD_W-1:0] speed;
    modport source (output valid, output op, output channel, output speed, input ready);
    modport sink   (input valid, input op, input channel, input speed, output ready);
endinterface

interface csot_rsp_if
    import csot_pkg::*;
();
    logic             valid;
    logic             ready;
    status_t          status;
    logic [KEY_W-1:0] target_channel;
    modport source (output valid, output status, output target_channel, input ready);
    modport sink   (input valid, input status, input target_channel, output ready);
endinterface

interface csot_cfg_if
    import csot_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/channel_speed_outlier_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the channel speed outlier tracker: channel table, sequencer and z-score test.
// It depends on csot_pkg, the interfaces in csot_if and the shared multiplier csot_mul.
//
// Use: requests arrive on req (op, channel, speed); each one gives exactly one transfer on
// rsp (status, target_channel). Register writes arrive on cfg (index 0 deviation factor,
// index 1 minimum count) and are always taken; the user must make them only while the
// block is idle, as the block itself does not enforce it. The block takes one request at a
// time: req.ready is high only while it is idle. Every request first walks the 16-entry
// table, one entry per cycle, and a starved report, a removal, a full table or a test
// skipped by the count or the mean goes to the result straight after it. When the
// deviation test runs, each valid entry costs one pass of the shared bit-serial
// multiplier, followed by two more passes.
// The result sits in an output register; while the receiver stalls it holds, and the block
// waits with its next result but stays idle for a new request as soon as the register can
// take the one it has. Reset empties the table and loads the register reset values.
module channel_speed_outlier_tracker
    import csot_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    csot_req_if.sink   req,
    csot_rsp_if.source rsp,
    csot_cfg_if.sink   cfg
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_VAR    = 4'd4;
    localparam logic [3:0] S_VMUL   = 4'd5;
    localparam logic [3:0] S_DIFF   = 4'd6;
    localparam logic [3:0] S_LMUL   = 4'd7;
    localparam logic [3:0] S_RSTART = 4'd8;
    localparam logic [3:0] S_RMUL   = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CHANNELS - 1);

    logic [MAX_CHANNELS-1:0] valid_reg, valid_next;
    logic [KEY_W-1:0]        key_mem [MAX_CHANNELS];
    logic [SPD_W-1:0]        spd_mem [MAX_CHANNELS];
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_idx;
    logic                    wr_key;

    logic [DEV_W-1:0]   dev_reg;
    logic [MINC_W-1:0]  minc_reg;

    logic [3:0]         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               op_reg, op_next;
    logic [KEY_W-1:0]   ch_reg, ch_next;
    logic [SPD_W-1:0]   spd_reg, spd_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   match_reg, match_next;
    logic               free_reg, free_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               best_reg, best_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [SPD_W-1:0]   best_spd_reg, best_spd_next;
    logic [KEY_W-1:0]   best_key_reg, best_key_next;
    logic [VAR_W-1:0]   var_reg, var_next;
    logic [MUL_P_W-1:0] lhs_reg, lhs_next;
    status_t            res_st_reg, res_st_next;
    logic [KEY_W-1:0]   res_tgt_reg, res_tgt_next;

    logic               out_valid_reg, out_valid_next;
    status_t            out_st_reg, out_st_next;
    logic [KEY_W-1:0]   out_tgt_reg, out_tgt_next;

    logic               mul_start;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_done;
    logic [MUL_P_W-1:0] mul_p;

    logic               cur_valid;
    logic [KEY_W-1:0]   cur_key;
    logic [SPD_W-1:0]   cur_spd;
    logic [NX_W-1:0]    nx_full;
    logic [SUM_W-1:0]   nx;
    logic [SUM_W-1:0]   dev_abs;
    logic [NX_W-1:0]    ns_full;
    logic [SUM_W-1:0]   diff;
    logic [CNT_W-1:0]   n_minus1;
    logic [MUL_P_W-1:0] lhs_prod;

    csot_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    assign cur_valid = valid_reg[idx_reg];
    assign cur_key   = key_mem[idx_reg];
    assign cur_spd   = spd_mem[idx_reg];
    assign nx_full   = NX_W'(n_reg) * NX_W'(cur_spd);
    assign nx        = nx_full[SUM_W-1:0];
    assign dev_abs   = (nx >= sum_reg) ? (nx - sum_reg) : (sum_reg - nx);
    assign ns_full   = NX_W'(n_reg) * NX_W'(spd_reg);
    assign diff      = sum_reg - ns_full[SUM_W-1:0];
    assign n_minus1  = n_reg - 1'b1;
    assign lhs_prod  = (MUL_P_W'(mul_p[2*SUM_W-1:0]) * MUL_P_W'(n_minus1)) << 16;

    assign req.ready      = (state_reg == S_IDLE);
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_st_reg;
    assign rsp.target_channel = out_tgt_reg;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        op_next       = op_reg;
        ch_next       = ch_reg;
        spd_next      = spd_reg;
        found_next    = found_reg;
        match_next    = match_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        n_next        = n_reg;
        sum_next      = sum_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        best_spd_next = best_spd_reg;
        best_key_next = best_key_reg;
        var_next      = var_reg;
        lhs_next      = lhs_reg;
        res_st_next   = res_st_reg;
        res_tgt_next  = res_tgt_reg;
        valid_next    = valid_reg;
        wr_en         = 1'b0;
        wr_idx        = match_reg;
        wr_key        = 1'b0;
        mul_start     = 1'b0;
        mul_a         = MUL_A_W'(dev_abs);
        mul_b         = dev_abs;
        out_valid_next = out_valid_reg;
        out_st_next    = out_st_reg;
        out_tgt_next   = out_tgt_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.op;
                    ch_next    = req.channel;
                    spd_next   = req.speed;
                    idx_next   = '0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    best_next  = 1'b0;
                    n_next     = '0;
                    sum_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cur_valid && cur_key == ch_reg)
                begin
                    found_next = 1'b1;
                    match_next = idx_reg;
                end
                else if (cur_valid)
                begin
                    n_next   = n_reg + 1'b1;
                    sum_next = sum_reg + SUM_W'(cur_spd);
                    if (!best_reg || cur_spd < best_spd_reg ||
                        (cur_spd == best_spd_reg && cur_key < best_key_reg))
                    begin
                        best_next     = 1'b1;
                        best_idx_next = idx_reg;
                        best_spd_next = cur_spd;
                        best_key_next = cur_key;
                    end
                end
                if (!cur_valid && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = idx_reg;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                res_tgt_next = '0;
                state_next   = S_OUT;
                if (op_reg == OP_STARVED)
                begin
                    if (found_reg)
                    begin
                        valid_next[match_reg] = 1'b0;
                    end
                    if (best_reg)
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                        res_tgt_next = best_key_reg;
                        res_st_next  = ST_SPLIT;
                    end
                    else
                    begin
                        res_st_next = ST_STALL;
                    end
                end
                else if (spd_reg == '1 || spd_reg == '0)
                begin
                    if (found_reg)
                    begin
                        valid_next[match_reg] = 1'b0;
                    end
                    res_st_next = (spd_reg == '0) ? ST_STALLED : ST_EXHAUSTED;
                end
                else if (found_reg || free_reg)
                begin
                    wr_en  = 1'b1;
                    wr_idx = found_reg ? match_reg : free_idx_reg;
                    wr_key = !found_reg;
                    valid_next[wr_idx] = 1'b1;
                    n_next     = n_reg + 1'b1;
                    sum_next   = sum_reg + SUM_W'(spd_reg);
                    state_next = S_CHECK;
                end
                else
                begin
                    res_st_next = ST_FULL;
                end
            end
            S_CHECK:
            begin
                res_st_next = ST_OK;
                idx_next    = '0;
                var_next    = '0;
                if (n_reg <= CNT_W'(minc_reg) && {1'b0, minc_reg} >= (MINC_W + 1)'(n_reg))
                begin
                    state_next = S_OUT;
                end
                else if (ns_full >= NX_W'(sum_reg))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_VAR;
                end
            end
            S_VAR:
            begin
                if (cur_valid)
                begin
                    mul_start  = 1'b1;
                    state_next = S_VMUL;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DIFF;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_VMUL:
            begin
                if (mul_done)
                begin
                    var_next = var_reg + mul_p[VAR_W-1:0];
                    idx_next = idx_reg + 1'b1;
                    state_next = (idx_reg == LAST_IDX) ? S_DIFF : S_VAR;
                end
            end
            S_DIFF:
            begin
                mul_start  = 1'b1;
                mul_a      = MUL_A_W'(diff);
                mul_b      = diff;
                state_next = S_LMUL;
            end
            S_LMUL:
            begin
                if (mul_done)
                begin
                    lhs_next   = lhs_prod;
                    state_next = S_RSTART;
                end
            end
            S_RSTART:
            begin
                mul_start  = 1'b1;
                mul_a      = var_reg;
                mul_b      = MUL_B_W'(MUL_B_W'(dev_reg) * MUL_B_W'(dev_reg));
                state_next = S_RMUL;
            end
            S_RMUL:
            begin
                if (mul_done)
                begin
                    res_st_next = (lhs_reg > mul_p) ? ST_SLOW : ST_OK;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = res_st_reg;
                    out_tgt_next   = res_tgt_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            dev_reg       <= DEV_RESET;
            minc_reg      <= MINC_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.index == CFG_DEVIATION)
            begin
                dev_reg <= cfg.data[DEV_W-1:0];
            end
            if (cfg.valid && cfg.index == CFG_MIN_COUNT)
            begin
                minc_reg <= cfg.data[MINC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        op_reg       <= op_next;
        ch_reg       <= ch_next;
        spd_reg      <= spd_next;
        found_reg    <= found_next;
        match_reg    <= match_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        n_reg        <= n_next;
        sum_reg      <= sum_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        best_spd_reg <= best_spd_next;
        best_key_reg <= best_key_next;
        var_reg      <= var_next;
        lhs_reg      <= lhs_next;
        res_st_reg   <= res_st_next;
        res_tgt_reg  <= res_tgt_next;
        out_st_reg   <= out_st_next;
        out_tgt_reg  <= out_tgt_next;
        if (wr_en)
        begin
            spd_mem[wr_idx] <= spd_reg;
            if (wr_key)
            begin
                key_mem[wr_idx] <= ch_reg;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/csot_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared shift-and-add multiplier of the tracker, one multiplier bit per cycle.
// It depends on csot_pkg for operand widths.
module csot_mul
    import csot_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [MUL_A_W-1:0] a,
    input  wire logic [MUL_B_W-1:0] b,
    output logic                    done,
    output logic [MUL_P_W-1:0]      p
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MUL_P_W-1:0]   acc_reg, acc_next;
    logic [MUL_P_W-1:0]   mcand_reg, mcand_next;
    logic [MUL_B_W-1:0]   mplier_reg, mplier_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start && !busy_reg)
        begin
            busy_next   = 1'b1;
            cnt_next    = MUL_CNT_W'(MUL_B_W);
            acc_next    = '0;
            mcand_next  = {{MUL_B_W{1'b0}}, a};
            mplier_next = b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule
`default_nettype wire
